@@ design/zcpm_pkg.sv @@
// ----------------------------------------------------------------------------
// zcpm_pkg
// Shared widths and the result record of the zero-crossing period meter.
// ----------------------------------------------------------------------------
package zcpm_pkg;

	localparam int SampleW = 16;
	localparam int WordW   = 32;
	localparam int NWords  = 7;
	localparam int DataW   = NWords * WordW;
	localparam int UserW   = 2;

	// Packed with the last member in the lowest bits, so the order below
	// is the reverse of the order on tdata.
	typedef struct packed {
		logic [WordW-1:0] sample_total;
		logic [WordW-1:0] mismatch_total;
		logic [WordW-1:0] edge_total;
		logic [WordW-1:0] period_total;
		logic [WordW-1:0] period_max;
		logic [WordW-1:0] period_min;
		logic [WordW-1:0] period_length;
	} zcpm_words_t;

	typedef struct packed {
		logic period_done;
		logic edge_seen;
	} zcpm_flags_t;

endpackage

@@ design/zero_crossing_period_meter_core.sv @@
// ----------------------------------------------------------------------------
// zero_crossing_period_meter_core
// Rising zero-crossing detector with period length, min/max and counters.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: 7 statistic words
//                                                tuser: edge_seen, period_done
//  cfg       in   cfg_we                         cfg_wdata: expected_period
//
//  One request per cycle when not stalled; input register, then result register.
//  All statistics are updated when a sample moves from the input register into
//  the result register. A stalled result register holds; the input register
//  still takes one request behind it. Reset clears all statistics at once.
// ----------------------------------------------------------------------------
module zero_crossing_period_meter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [zcpm_pkg::SampleW-1:0]  s_axis_tdata,  // [15:0] sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] period_length, [63:32] period_min, [95:64] period_max,
	// [127:96] period_total, [159:128] edge_total, [191:160] mismatch_total,
	// [223:192] sample_total
	output logic [zcpm_pkg::DataW-1:0]    m_axis_tdata,
	output logic [zcpm_pkg::UserW-1:0]    m_axis_tuser,  // [0] edge_seen, [1] period_done
	input  logic                          cfg_we,
	input  logic [zcpm_pkg::WordW-1:0]    cfg_wdata      // expected_period
);
	import zcpm_pkg::*;

	logic [WordW-1:0]   expected_q;
	logic               valid_s1;
	logic [SampleW-1:0] sample_s1;
	logic               valid_s2;
	zcpm_words_t        words_s2;
	zcpm_flags_t        flags_s2;

	logic [SampleW-1:0] last_sample_q;
	logic               last_valid_q;
	logic [WordW-1:0]   sample_cnt_q;
	logic [WordW-1:0]   last_edge_q;
	logic               edge_valid_q;
	logic [WordW-1:0]   edge_cnt_q;
	logic [WordW-1:0]   period_cnt_q;
	logic [WordW-1:0]   min_q;
	logic [WordW-1:0]   max_q;
	logic [WordW-1:0]   mismatch_q;

	logic               advance;
	logic               last_nonpos;
	logic               cur_pos;
	logic               edge_hit;
	logic               done;
	logic [WordW-1:0]   length;
	logic [WordW-1:0]   min_d;
	logic [WordW-1:0]   max_d;
	logic [WordW-1:0]   mismatch_d;
	logic [WordW-1:0]   period_cnt_d;
	logic [WordW-1:0]   edge_cnt_d;
	logic [WordW-1:0]   sample_cnt_d;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign last_nonpos = last_sample_q[SampleW-1] || (last_sample_q == '0);
	assign cur_pos     = !sample_s1[SampleW-1] && (sample_s1 != '0);
	assign edge_hit    = last_valid_q && last_nonpos && cur_pos;
	assign done        = edge_hit && edge_valid_q;
	assign length      = sample_cnt_q - last_edge_q;

	always_comb begin
		min_d        = min_q;
		max_d        = max_q;
		mismatch_d   = mismatch_q;
		period_cnt_d = period_cnt_q;
		if (done) begin
			if ((period_cnt_q == '0) || (length < min_q)) begin
				min_d = length;
			end
			if (length > max_q) begin
				max_d = length;
			end
			if (length != expected_q) begin
				mismatch_d = mismatch_q + 1'b1;
			end
			period_cnt_d = period_cnt_q + 1'b1;
		end
		edge_cnt_d   = edge_hit ? edge_cnt_q + 1'b1 : edge_cnt_q;
		sample_cnt_d = sample_cnt_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (cfg_we) begin
			expected_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			last_sample_q <= '0;
			last_valid_q  <= 1'b0;
			sample_cnt_q  <= '0;
			last_edge_q   <= '0;
			edge_valid_q  <= 1'b0;
			edge_cnt_q    <= '0;
			period_cnt_q  <= '0;
			min_q         <= '0;
			max_q         <= '0;
			mismatch_q    <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				last_sample_q <= sample_s1;
				last_valid_q  <= 1'b1;
				sample_cnt_q  <= sample_cnt_d;
				if (edge_hit) begin
					last_edge_q  <= sample_cnt_q;
					edge_valid_q <= 1'b1;
				end
				edge_cnt_q   <= edge_cnt_d;
				period_cnt_q <= period_cnt_d;
				min_q        <= min_d;
				max_q        <= max_d;
				mismatch_q   <= mismatch_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2.edge_seen      <= edge_hit;
			flags_s2.period_done    <= done;
			words_s2.period_length  <= done ? length : '0;
			words_s2.period_min     <= min_d;
			words_s2.period_max     <= max_d;
			words_s2.period_total   <= period_cnt_d;
			words_s2.edge_total     <= edge_cnt_d;
			words_s2.mismatch_total <= mismatch_d;
			words_s2.sample_total   <= sample_cnt_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = words_s2;
	assign m_axis_tuser  = flags_s2;

	a_done_has_edge: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (flags_s2.edge_seen || !flags_s2.period_done))
		else $error("period closed without an edge");

	a_length_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !flags_s2.period_done) |-> (words_s2.period_length == '0))
		else $error("period length nonzero without a closed period");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= max_q)
		else $error("minimum period above maximum");

	a_no_period_before_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!edge_valid_q |-> (period_cnt_q == '0))
		else $error("period counted before the first edge");

	a_sample_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (sample_cnt_q == $past(sample_cnt_q) + 1'b1))
		else $error("sample counter did not step");

endmodule

@@ test/zero_crossing_period_meter_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zero_crossing_period_meter_core_test
// Streams audio samples through the period meter and checks every statistics
// request against a cycle-free predictor, with random idling on both sides,
// one long output stall and several expected-period settings.
// ----------------------------------------------------------------------------
module zero_crossing_period_meter_core_test;

	import zcpm_pkg::*;

	localparam int IdleLimit = 5000;
	localparam int HoldCycles = 300;

	typedef logic signed [SampleW-1:0] sample_t;

	typedef struct packed {
		zcpm_flags_t flags;
		zcpm_words_t words;
	} meter_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SampleW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DataW-1:0] m_axis_tdata;
	logic [UserW-1:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [WordW-1:0] cfg_wdata = '0;

	zero_crossing_period_meter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	sample_t pending_samples[$];
	meter_stats_t expected_stats[$];
	int failures = 0;
	bit calm = 1'b0;
	int hold_asked = 0;
	int hold_taken = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int idle_cycles = 0;

	// predictor state
	logic [WordW-1:0] period_goal = '0;
	sample_t prev_sample = '0;
	logic prev_valid = 1'b0;
	logic [WordW-1:0] sample_count = '0;
	logic [WordW-1:0] last_edge_at = '0;
	logic edge_armed = 1'b0;
	logic [WordW-1:0] edge_count = '0;
	logic [WordW-1:0] period_count = '0;
	logic [WordW-1:0] shortest = '0;
	logic [WordW-1:0] longest = '0;
	logic [WordW-1:0] mismatch_count = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic meter_stats_t measure_sample(sample_t cur);
		meter_stats_t r;
		logic rise;
		logic [WordW-1:0] span;
		r = '0;
		span = '0;
		rise = prev_valid && (prev_sample <= 0) && (cur > 0);
		if (rise) begin
			if (edge_armed) begin
				span = sample_count - last_edge_at;
				if (period_count == 0 || span < shortest)
					shortest = span;
				if (span > longest)
					longest = span;
				if (span != period_goal)
					mismatch_count = mismatch_count + 1;
				period_count = period_count + 1;
				r.flags.period_done = 1'b1;
			end
			last_edge_at = sample_count;
			edge_armed = 1'b1;
			edge_count = edge_count + 1;
		end
		prev_sample = cur;
		prev_valid = 1'b1;
		sample_count = sample_count + 1;
		r.flags.edge_seen = rise;
		r.words.period_length = span;
		r.words.period_min = shortest;
		r.words.period_max = longest;
		r.words.period_total = period_count;
		r.words.edge_total = edge_count;
		r.words.mismatch_total = mismatch_count;
		r.words.sample_total = sample_count;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_word(string what, logic [WordW-1:0] want, logic [WordW-1:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
			failures++;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			tx_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_stats.push_back(measure_sample(s_axis_tdata));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold request
			end else if (tx_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (pending_samples.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_samples.pop_front();
				if (!calm && $urandom_range(0, 9) < 3)
					tx_wait <= gap_len();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		meter_stats_t got;
		meter_stats_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata};
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h", $time, got);
					failures++;
				end else begin
					want = expected_stats.pop_front();
					check_word("edge_seen", WordW'(want.flags.edge_seen),
						WordW'(got.flags.edge_seen));
					check_word("period_done", WordW'(want.flags.period_done),
						WordW'(got.flags.period_done));
					check_word("period_length", want.words.period_length,
						got.words.period_length);
					check_word("period_min", want.words.period_min, got.words.period_min);
					check_word("period_max", want.words.period_max, got.words.period_max);
					check_word("period_total", want.words.period_total,
						got.words.period_total);
					check_word("edge_total", want.words.edge_total, got.words.edge_total);
					check_word("mismatch_total", want.words.mismatch_total,
						got.words.mismatch_total);
					check_word("sample_total", want.words.sample_total,
						got.words.sample_total);
				end
			end
			if (rx_wait != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait <= rx_wait - 1;
			end else if (hold_taken != hold_asked) begin
				m_axis_tready <= 1'b0;
				rx_wait <= HoldCycles - 1;
				hold_taken <= hold_taken + 1;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					rx_wait <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IdleLimit) begin
			$display("%0t: no request moved for %0d cycles", $time, IdleLimit);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_period_goal(logic [WordW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		period_goal = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= $urandom();
	endtask

	// periods of a nonpositive stretch followed by a positive one; a broken wave keeps its last period nonpositive
	task automatic add_wave(int period, int cycles, bit broken);
		int low_len;
		for (int c = 0; c < cycles; c++) begin
			low_len = $urandom_range(1, period - 1);
			for (int k = 0; k < period; k++) begin
				if (k < low_len || (broken && c == cycles - 1))
					pending_samples.push_back(sample_t'(-int'($urandom_range(0, 32768))));
				else
					pending_samples.push_back(sample_t'($urandom_range(1, 32767)));
			end
		end
	endtask

	task automatic add_random(int count, int favored);
		int r;
		int p;
		int n;
		while (count > 0) begin
			r = $urandom_range(0, 9);
			p = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(2, 40);
			if (r < 4)
				p = favored;
			if (r < 7) begin
				n = $urandom_range(1, 6);
				add_wave(p, n, 1'b0);
				count -= p * n;
			end else if (r == 7) begin
				p = $urandom_range(1, 8);
				repeat (p) pending_samples.push_back(sample_t'($urandom()));
				count -= p;
			end else begin
				n = $urandom_range(1, 3);
				add_wave(p, n, 1'b1);
				count -= p * n;
			end
		end
	endtask

	task automatic add_list(int vals[$]);
		foreach (vals[i])
			pending_samples.push_back(sample_t'(vals[i]));
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first sample cannot form an edge, zero counts as nonpositive,
		// full-scale swings, new min and max, match and mismatch
		set_period_goal(3);
		@(negedge clk);
		add_list('{32767, 0, 1, -1, -32768, 32767, 32767, 1, 0, 0, 1, -1, 1,
			-32768, 1, 0, 0, -1, 0, 32767, -32768, -32768, -32768, 2});
		wait_drained();

		// all-ones goal, long output stall while input keeps coming
		set_period_goal(32'hFFFF_FFFF);
		@(negedge clk);
		add_random(220, $urandom_range(2, 40));
		hold_asked = hold_asked + 1;
		wait_drained();

		// zero goal, no idling
		set_period_goal(0);
		calm = 1'b1;
		@(negedge clk);
		add_random(200, $urandom_range(2, 40));
		wait_drained();
		calm = 1'b0;

		// goal at the shortest possible period
		set_period_goal(2);
		@(negedge clk);
		add_random(180, 2);
		wait_drained();

		p = $urandom_range(3, 40);
		set_period_goal(p);
		@(negedge clk);
		add_random(200, p);
		wait_drained();

		p = $urandom_range(3, 40);
		set_period_goal(p);
		@(negedge clk);
		add_random(200, p);
		wait_drained();

		repeat (10) @(posedge clk);
		if (expected_stats.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0 pending", $time,
				expected_stats.size());
			failures++;
		end
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
